// ----- rtl/mac_address_dedup_filter_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the duplicate address filter
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef MAC_ADDRESS_DEDUP_FILTER_DEFINES_SVH
`define MAC_ADDRESS_DEDUP_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MADF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MADF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/madf_pkg.sv -----
// ---------------------------------------------------------------------------
// madf_pkg
// Sizes, controller states and the command and status bundles of the filter.
// ---------------------------------------------------------------------------
package madf_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W        = 48;
  localparam int CHAN_W        = 4;
  localparam int LEVEL_W       = 8;

  localparam logic [CNT_W-1:0] ENTRY_LIMIT = CNT_W'(TABLE_ENTRIES);

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STORE_RX,
    ST_STORE_TX,
    ST_EMIT
  } madf_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic store_rx;
    logic store_tx;
    logic clear;
    logic emit;
  } madf_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_free;
  } madf_status_t;

endpackage

// ----- rtl/madf_datapath.sv -----
// ---------------------------------------------------------------------------
// madf_datapath
// Request registers, seen-address memory, search counter and result register.
// ---------------------------------------------------------------------------
module madf_datapath
  import madf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  madf_cmd_t                 cmd,
  output madf_status_t              status,
  input  logic [ADDR_W-1:0]         in_rx_address,
  input  logic [ADDR_W-1:0]         in_tx_address,
  input  logic [CHAN_W-1:0]         in_radio_channel,
  input  logic signed [LEVEL_W-1:0] in_signal_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ADDR_W-1:0]         out_new_address,
  output logic [CHAN_W-1:0]         out_channel,
  output logic signed [LEVEL_W-1:0] out_level,
  output logic                      out_table_full
);

  logic [ADDR_W-1:0]         mem [TABLE_ENTRIES];

  logic [ADDR_W-1:0]         rx_r;
  logic [ADDR_W-1:0]         tx_r;
  logic [CHAN_W-1:0]         chan_r;
  logic signed [LEVEL_W-1:0] level_r;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      full_r, full_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]         rd_data_r;

  logic                      rd_en;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_data;
  logic                      has_room;

  assign has_room = (count_r < ENTRY_LIMIT);
  assign rd_en    = cmd.scan && (rd_idx_r < count_r);
  assign wr_en    = (cmd.store_rx || cmd.store_tx) && has_room;
  assign wr_data  = cmd.store_rx ? rx_r : tx_r;

  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end

    if (cmd.load) begin
      rd_idx_nxt  = '0;
      rd_pend_nxt = 1'b0;
      full_nxt    = 1'b0;
    end
    if (cmd.scan) begin
      rd_pend_nxt = rd_en;
      if (rd_en) begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
    end
    if (cmd.store_rx || cmd.store_tx) begin
      if (has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        full_nxt = 1'b1;
      end
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_r    <= in_rx_address;
      tx_r    <= in_tx_address;
      chan_r  <= in_radio_channel;
      level_r <= in_signal_level;
    end
    if (cmd.emit) begin
      out_new_address <= tx_r;
      out_channel     <= chan_r;
      out_level       <= level_r;
      out_table_full  <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign status.hit       = rd_pend_r && (rd_data_r == tx_r);
  assign status.scan_done = !rd_pend_r && (rd_idx_r >= count_r);
  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;

endmodule

// ----- rtl/madf_ctrl.sv -----
// ---------------------------------------------------------------------------
// madf_ctrl
// Sequencer for accept, table search, two stores and result hand-off.
// ---------------------------------------------------------------------------
module madf_ctrl
  import madf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_kind,
  input  madf_status_t status,
  output madf_cmd_t    cmd
);

  madf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // A hit on the entry read last cycle wins over the next read.
        priority if (status.hit) begin
          state_nxt = ST_IDLE;
        end else if (status.scan_done) begin
          state_nxt = ST_STORE_RX;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_STORE_RX: begin
        cmd.store_rx = 1'b1;
        state_nxt    = ST_STORE_TX;
      end
      ST_STORE_TX: begin
        cmd.store_tx = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/mac_address_dedup_filter.sv -----
// ---------------------------------------------------------------------------
// mac_address_dedup_filter
// A frame's transmitter address is searched among the stored entries through the
// one read port. On a miss both addresses are stored while room is left and a
// result is loaded into the output register; a duplicate produces no result. The
// input stays stalled until a duplicate matches, or for a new frame through the
// search, both stores and a hand-off delayed by a stalled result; a switch is not held.
// Reset (synchronous, active low) empties the table by zeroing its fill count.
// ---------------------------------------------------------------------------
`include "mac_address_dedup_filter_defines.svh"

module mac_address_dedup_filter
  import madf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [ADDR_W-1:0]         in_rx_address,
  input  logic [ADDR_W-1:0]         in_tx_address,
  input  logic [CHAN_W-1:0]         in_radio_channel,
  input  logic signed [LEVEL_W-1:0] in_signal_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ADDR_W-1:0]         out_new_address,
  output logic [CHAN_W-1:0]         out_channel,
  output logic signed [LEVEL_W-1:0] out_level,
  output logic                      out_table_full
);

  // The controller only sequences; every stored value lives in the datapath.
  // A frame request is captured, then the memory is read one entry per cycle
  // with the compare of the previous entry overlapping the next read. Only
  // entries below the fill count are read, so unwritten rows never matter.
  // On a miss the receiver and then the transmitter address are appended, if room
  // is left, through the single write port, and the result is loaded into the
  // output register. That register decouples the two sides: the next request is
  // taken while an earlier result still waits downstream.
  madf_cmd_t    cmd;
  madf_status_t status;

  madf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .status   (status),
    .cmd      (cmd)
  );

  madf_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_rx_address    (in_rx_address),
    .in_tx_address    (in_tx_address),
    .in_radio_channel (in_radio_channel),
    .in_signal_level  (in_signal_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_address  (out_new_address),
    .out_channel      (out_channel),
    .out_level        (out_level),
    .out_table_full   (out_table_full)
  );

  // The controller issues at most one command in any cycle.
  `MADF_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")

  // A result is only loaded when the output register can take it.
  `MADF_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free, "result overwrote a pending one")

  // A loaded result is presented on the next cycle.
  `MADF_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "loaded result not presented")

  // An accepted frame keeps the input side stalled while it is searched.
  `MADF_ASSERT_NEXT(a_frame_busy, in_valid && !in_stall && (in_kind == KIND_FRAME),
    in_stall, "new request taken during a search")

endmodule

// ----- sim/tb_mac_address_dedup_filter.sv -----
// ---------------------------------------------------------------------------
// tb_mac_address_dedup_filter
// Drives frames and channel switches into the duplicate address filter and
// checks every reported address against a software copy of the seen table.
// ---------------------------------------------------------------------------
module tb_mac_address_dedup_filter;
  import madf_pkg::*;

  // No new burst starts once this many requests have gone in.
  localparam int ITEM_TARGET    = 1850;
  // A frame against a full table must read every entry before it is done, so a
  // quiet stretch this long can only mean that the block has hung.
  localparam int WATCHDOG_LIMIT = 20000;
  // Cycles watched after the last report, to catch a stray extra result.
  localparam int TAIL_CYCLES    = TABLE_ENTRIES + 40;
  localparam int STEADY_ITEMS   = 300;
  localparam int IDLE_PERCENT   = 38;
  localparam int MAX_REPORTED   = 10;

  // One result as the block should report it. The level is kept as raw bits.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
    logic               full;
  } report_t;

  logic                      clk;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_stall;
  logic                      in_kind          = KIND_FRAME;
  logic [ADDR_W-1:0]         in_rx_address    = '0;
  logic [ADDR_W-1:0]         in_tx_address    = '0;
  logic [CHAN_W-1:0]         in_radio_channel = '0;
  logic signed [LEVEL_W-1:0] in_signal_level  = '0;
  logic                      out_valid;
  logic                      out_stall        = 1'b0;
  logic [ADDR_W-1:0]         out_new_address;
  logic [CHAN_W-1:0]         out_channel;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      out_table_full;

  // Shadow of the block's table: the addresses stored since the last switch.
  logic [ADDR_W-1:0] known_addresses [TABLE_ENTRIES];
  int unsigned       known_count = 0;

  report_t pending_reports [$];
  int      failures      = 0;
  int      requests_sent = 0;
  int      quiet_cycles  = 0;
  // While set, neither side inserts idle or stall cycles.
  logic    steady_flow   = 1'b0;

  mac_address_dedup_filter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_rx_address    (in_rx_address),
    .in_tx_address    (in_tx_address),
    .in_radio_channel (in_radio_channel),
    .in_signal_level  (in_signal_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_address  (out_new_address),
    .out_channel      (out_channel),
    .out_level        (out_level),
    .out_table_full   (out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTED) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic logic [ADDR_W-1:0] rand_address();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Works out what one accepted request does to the seen table and, for a
  // frame with an unknown transmitter, queues the report it must produce.
  // The scan only looks at entries below the fill count, exactly as the block
  // does, so entries left over from before a switch never match.
  function automatic void track_request(input logic kind,
                                        input logic [ADDR_W-1:0] rx,
                                        input logic [ADDR_W-1:0] tx,
                                        input logic [CHAN_W-1:0] chan,
                                        input logic [LEVEL_W-1:0] level);
    report_t fresh;
    logic    lost;
    if (kind == KIND_CLEAR) begin
      known_count = 0;
      return;
    end
    for (int i = 0; i < int'(known_count); i++) begin
      if (known_addresses[IDX_W'(i)] == tx) begin
        return;
      end
    end
    // The receiver address is stored first, so with one slot left it wins
    // and only the transmitter address is lost.
    lost = 1'b0;
    if (known_count < TABLE_ENTRIES) begin
      known_addresses[IDX_W'(known_count)] = rx;
      known_count++;
    end else begin
      lost = 1'b1;
    end
    if (known_count < TABLE_ENTRIES) begin
      known_addresses[IDX_W'(known_count)] = tx;
      known_count++;
    end else begin
      lost = 1'b1;
    end
    fresh.address = tx;
    fresh.channel = chan;
    fresh.level   = level;
    fresh.full    = lost;
    pending_reports.push_back(fresh);
  endfunction

  // Presents one request and holds it until the filter takes it. Valid stays
  // high on return so that back-to-back requests need no gap.
  task automatic send_request(input logic kind,
                              input logic [ADDR_W-1:0] rx,
                              input logic [ADDR_W-1:0] tx,
                              input logic [CHAN_W-1:0] chan,
                              input logic signed [LEVEL_W-1:0] level);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_rx_address    <= rx;
    in_tx_address    <= tx;
    in_radio_channel <= chan;
    in_signal_level  <= level;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    track_request(kind, rx, tx, chan, level);
    requests_sent++;
  endtask

  task automatic send_frame(input logic [ADDR_W-1:0] rx,
                            input logic [ADDR_W-1:0] tx,
                            input logic [CHAN_W-1:0] chan,
                            input logic signed [LEVEL_W-1:0] level);
    send_request(KIND_FRAME, rx, tx, chan, level);
  endtask

  // A channel switch carries random frame fields, which the block must ignore.
  task automatic send_switch();
    send_request(KIND_CLEAR, rand_address(), rand_address(), CHAN_W'($urandom()),
                 LEVEL_W'($urandom()));
  endtask

  // Field extremes and the basic filtering rules: a repeated transmitter is
  // dropped, a stored receiver address blocks a later frame from it, equal
  // addresses are both stored, and a switch makes every address new again.
  task automatic test_directed_cases();
    send_switch();
    send_frame('0, '1, '0, LEVEL_W'(-128));
    send_frame(48'h5555_5555_5555, '1, '1, LEVEL_W'(127));
    send_frame(48'hAAAA_AAAA_AAAA, '0, 4'd3, LEVEL_W'(0));
    send_frame(48'h0123_4567_89AB, 48'h0123_4567_89AB, 4'd7, LEVEL_W'(0));
    send_frame(48'hFEDC_BA98_7654, 48'h0123_4567_89AB, 4'd7, LEVEL_W'(5));
    send_frame(48'h8000_0000_0001, 48'h7FFF_FFFF_FFFE, 4'd8, LEVEL_W'(-1));
    // The receiver of a dropped frame was never stored, so it is still new.
    send_frame('0, 48'h5555_5555_5555, 4'd9, LEVEL_W'(1));
    send_frame(48'h7FFF_FFFF_FFFE, 48'h8000_0000_0001, 4'd10, LEVEL_W'(-2));
    send_request(KIND_CLEAR, '1, '1, '1, LEVEL_W'(-1));
    send_frame('1, '1, 4'd12, LEVEL_W'(64));
    send_frame('1, '0, 4'd13, LEVEL_W'(-64));
    send_switch();
    send_switch();
    send_frame(48'h0000_0000_0001, 48'hAAAA_AAAA_AAAA, 4'd1, LEVEL_W'(1));
    send_frame(48'hAAAA_AAAA_AAAA, 48'h0000_0000_0001, 4'd2, LEVEL_W'(2));
  endtask

  // Fills the table to capacity and goes past it: the frame that completes
  // the table still fits, the next new ones are reported with the full flag and
  // their addresses are not stored, so they stay new.
  task automatic test_table_capacity();
    logic [ADDR_W-1:0] first_rx;
    logic [ADDR_W-1:0] first_tx;
    logic [ADDR_W-1:0] lost_tx;
    first_rx = rand_address();
    first_tx = rand_address();
    lost_tx  = rand_address();
    send_switch();
    send_frame(first_rx, first_tx, CHAN_W'($urandom()), LEVEL_W'($urandom()));
    for (int n = 1; n < TABLE_ENTRIES / 2; n++) begin
      send_frame(rand_address(), rand_address(), CHAN_W'($urandom()),
                 LEVEL_W'($urandom()));
    end
    send_frame(rand_address(), lost_tx, 4'd4, LEVEL_W'(-100));
    send_frame(rand_address(), lost_tx, 4'd5, LEVEL_W'(100));
    send_frame(rand_address(), first_tx, 4'd6, LEVEL_W'(0));
    send_frame(lost_tx, first_rx, 4'd6, LEVEL_W'(0));
    send_switch();
    send_frame(first_rx, first_tx, 4'd11, LEVEL_W'(-50));
  endtask

  // Bursts of frames drawn from a small address pool, so repeats are common,
  // mostly closed by a channel switch. Now and then a burst of fresh
  // addresses can run the table into capacity, and stray switches break bursts.
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] pool [16];
    int                pool_size;
    int                burst_len;
    logic              fill_burst;
    logic [ADDR_W-1:0] rx;
    logic [ADDR_W-1:0] tx;
    int                start_count;
    start_count = requests_sent;
    steady_flow <= 1'b1;
    while (requests_sent < ITEM_TARGET) begin
      if (requests_sent - start_count >= STEADY_ITEMS) begin
        steady_flow <= 1'b0;
      end
      fill_burst = ($urandom_range(0, 99) < 4);
      burst_len  = fill_burst ? $urandom_range(120, 150) : $urandom_range(3, 40);
      pool_size  = $urandom_range(2, 16);
      for (int p = 0; p < pool_size; p++) begin
        case ($urandom_range(0, 19))
          0:       pool[4'(p)] = '0;
          1:       pool[4'(p)] = '1;
          default: pool[4'(p)] = rand_address();
        endcase
      end
      for (int k = 0; k < burst_len; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          send_switch();
        end
        if (fill_burst) begin
          rx = rand_address();
          tx = rand_address();
        end else begin
          rx = ($urandom_range(0, 9) == 0) ? rand_address()
                                          : pool[4'($urandom_range(0, pool_size - 1))];
          tx = ($urandom_range(0, 9) == 0) ? rand_address()
                                          : pool[4'($urandom_range(0, pool_size - 1))];
          if ($urandom_range(0, 9) == 0) begin
            tx = rx;
          end
        end
        send_frame(rx, tx, CHAN_W'($urandom()), LEVEL_W'($urandom()));
      end
      if ($urandom_range(0, 99) < 85) begin
        send_switch();
      end
    end
    steady_flow <= 1'b0;
  endtask

  // The result side stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Each accepted result must match the oldest report still waiting.
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_failure($sformatf("unexpected result: address %h channel %0d level %0d full %b",
                               out_new_address, out_channel, out_level, out_table_full));
      end else begin
        want = pending_reports.pop_front();
        if (out_new_address !== want.address || out_channel !== want.channel ||
            out_level !== want.level || out_table_full !== want.full) begin
          flag_failure($sformatf({"mismatch: expected address %h channel %0d level %0d ",
                                  "full %b, got address %h channel %0d level %0d full %b"},
                                 want.address, want.channel, $signed(want.level),
                                 want.full, out_new_address, out_channel, out_level,
                                 out_table_full));
        end
      end
    end
  end

  // Ends a run in which neither channel moves for far longer than any
  // correct request could take.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_table_capacity();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      flag_failure($sformatf("%0d reports never arrived", pending_reports.size()));
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/madf_pkg.sv
rtl/madf_datapath.sv
rtl/madf_ctrl.sv
rtl/mac_address_dedup_filter.sv
sim/tb_mac_address_dedup_filter.sv
